// ===== rtl/radix_digit_emitter_defines.svh =====
// Assertion macros for the radix digit emitter.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RDE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define RDE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RDE_ASSERT_NOW(lbl, ante, cons)
`define RDE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/rde_pkg.sv =====
package rde_pkg;

   localparam int CFG_W     = 64;
   localparam int ALPHA_W   = 2 * CFG_W;
   localparam int CHAR_W    = 8;
   localparam int COUNT_W   = 6;
   localparam int LEN_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_W     = 32;
   // Quotient bits that the shared divider resolves per cycle.
   localparam int STEP_BITS = 4;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [CHAR_W-1:0]    char_type;

   localparam csr_index_type CSR_ALPHA_LO = 2'd0;
   localparam csr_index_type CSR_ALPHA_HI = 2'd1;
   localparam csr_index_type CSR_BASE_LEN = 2'd2;

   localparam char_type CHAR_NUL   = 8'h00;
   localparam char_type CHAR_PLUS  = 8'h2B;
   localparam char_type CHAR_MINUS = 8'h2D;

   localparam logic [LEN_W-1:0] MIN_RADIX = 5'd2;

endpackage

// ===== rtl/radix_digit_emitter.sv =====
// The first character is presented once the division of every digit and the alphabet
// check have both finished and the digit memory has been read (ST_EMIT_RD, ST_EMIT_LD).
// Throughput: one character per cycle once emission starts, while the output is not stalled;
// a new number is taken the cycle after its last character enters the output register.
// The divider resolves four quotient bits per cycle.
// Reset (synchronous, active high) clears the alphabet, radix, state, flags and output valid.
`include "radix_digit_emitter_defines.svh"

module radix_digit_emitter #(
   parameter int MAX_RADIX   = 16,
   parameter int NUMBER_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rde_pkg::NUM_W-1:0]     req_number,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rde_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last,
   output logic                          rsp_bad_base,
   output logic [rde_pkg::COUNT_W-1:0]   rsp_char_count,
   // Configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  rde_pkg::csr_index_type        csr_index,
   input  logic [rde_pkg::CFG_W-1:0]     csr_data
);

   // Remainders fit in REM_W bits; the radix itself needs one bit more.
   localparam int REM_W  = $clog2(MAX_RADIX);
   localparam int RAD_W  = REM_W + 1;
   localparam int SYM_N  = 2 ** REM_W;
   localparam int STEPS  = (NUMBER_BITS + rde_pkg::STEP_BITS - 1) / rde_pkg::STEP_BITS;
   localparam int PAD_W  = STEPS * rde_pkg::STEP_BITS;
   localparam int STP_W  = $clog2(STEPS);
   localparam int CNT_W  = $clog2(NUMBER_BITS + 1);
   localparam int ADDR_W = $clog2(NUMBER_BITS);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE    = 3'd0;  // waiting for a number
   localparam logic [2:0] ST_DIV     = 3'd1;  // dividing and checking the alphabet
   localparam logic [2:0] ST_EMIT_RD = 3'd2;  // first read of the digit memory
   localparam logic [2:0] ST_EMIT_LD = 3'd3;  // one character per free output slot
   localparam logic [2:0] ST_BAD     = 3'd4;  // single bad-base result

   // Configuration registers.
   logic [rde_pkg::CFG_W-1:0] alpha_lo_ff;
   logic [rde_pkg::CFG_W-1:0] alpha_hi_ff;
   logic [rde_pkg::LEN_W-1:0] base_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_lo_ff <= '0;
         alpha_hi_ff <= '0;
         base_len_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            rde_pkg::CSR_ALPHA_LO: alpha_lo_ff <= csr_data;
            rde_pkg::CSR_ALPHA_HI: alpha_hi_ff <= csr_data;
            rde_pkg::CSR_BASE_LEN: base_len_ff <= csr_data[rde_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Alphabet unpacked into one character per digit value.
   logic [rde_pkg::ALPHA_W-1:0] alpha;
   rde_pkg::char_type           sym [SYM_N];

   assign alpha = {alpha_hi_ff, alpha_lo_ff};

   always_comb begin
      for (int k = 0; k < SYM_N; k++) begin
         sym[k] = alpha[8*k +: 8];
      end
   end

   // Sequencer and datapath registers.
   logic [2:0]        state_ff,    state_in;
   logic [PAD_W-1:0]  quo_ff,      quo_in;
   logic [REM_W-1:0]  rem_ff,      rem_in;
   logic [STP_W-1:0]  stp_ff,      stp_in;
   logic [CNT_W-1:0]  cnt_ff,      cnt_in;
   logic [REM_W-1:0]  chk_ff,      chk_in;
   logic              chk_done_ff, chk_done_in;
   logic              div_done_ff, div_done_in;
   logic              bad_ff,      bad_in;
   logic [ADDR_W-1:0] ptr_ff,      ptr_in;
   logic [REM_W-1:0]  rd_data_ff;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   rde_pkg::char_type           rsp_char_ff,  rsp_char_in;
   logic                        rsp_last_ff,  rsp_last_in;
   logic                        rsp_bad_ff,   rsp_bad_in;
   logic [rde_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // The digit memory holds the remainders of the current number, least significant
   // digit at address zero.
   logic [REM_W-1:0]  digit_mem_ff [NUMBER_BITS];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [REM_W-1:0]  rem_new;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem_ff[wr_addr] <= rem_new;
      end
      rd_data_ff <= digit_mem_ff[rd_addr];
   end

   // Shared divider: restoring division by the radix, STEP_BITS quotient bits per cycle.
   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   logic [RAD_W-1:0] radix;
   logic [PAD_W-1:0] quo_new;

   assign radix = base_len_ff[RAD_W-1:0];

   always_comb begin
      logic [REM_W-1:0] r;
      logic [PAD_W-1:0] q;
      logic [RAD_W-1:0] p;
      logic             ge;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < rde_pkg::STEP_BITS; i++) begin
         p  = {r, q[PAD_W-1]};
         ge = (p >= radix);
         if (ge) begin
            r = REM_W'(p - radix);
         end else begin
            r = p[REM_W-1:0];
         end
         q = {q[PAD_W-2:0], ge};
      end
      rem_new = r;
      quo_new = q;
   end

   // Alphabet check: one character per cycle against a sign, a zero byte and every lower-numbered character.
   logic              len_bad;
   logic              chk_bad;
   rde_pkg::char_type chk_char;

   assign len_bad = (base_len_ff < rde_pkg::MIN_RADIX) ||
                    (base_len_ff > rde_pkg::LEN_W'(MAX_RADIX));
   assign chk_char = sym[chk_ff];

   always_comb begin
      logic dup;
      logic in_use;
      dup    = 1'b0;
      in_use = (rde_pkg::LEN_W'(chk_ff) < base_len_ff);
      for (int b = 0; b < MAX_RADIX; b++) begin
         if ((REM_W'(b) < chk_ff) && (sym[b] == chk_char)) begin
            dup = 1'b1;
         end
      end
      chk_bad = in_use && ((chk_char == rde_pkg::CHAR_NUL) ||
                           (chk_char == rde_pkg::CHAR_PLUS) ||
                           (chk_char == rde_pkg::CHAR_MINUS) || dup);
   end

   logic out_free;
   logic digit_end;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign digit_end = (stp_ff == STP_W'(STEPS - 1));
   assign wr_addr   = cnt_ff[ADDR_W-1:0];
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      stp_in       = stp_ff;
      cnt_in       = cnt_ff;
      chk_in       = chk_ff;
      chk_done_in  = chk_done_ff;
      div_done_in  = div_done_ff;
      bad_in       = bad_ff;
      ptr_in       = ptr_ff;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in    = ST_DIV;
               quo_in      = PAD_W'(req_number[NUMBER_BITS-1:0]);
               rem_in      = '0;
               stp_in      = '0;
               cnt_in      = '0;
               chk_in      = '0;
               chk_done_in = 1'b0;
               div_done_in = 1'b0;
               bad_in      = len_bad;
            end
         end

         ST_DIV: begin
            if (!div_done_ff) begin
               quo_in = quo_new;
               if (digit_end) begin
                  // One digit finished: store it and restart on the quotient.
                  wr_en  = 1'b1;
                  rem_in = '0;
                  stp_in = '0;
                  cnt_in = cnt_ff + 1'b1;
                  if ((quo_new == '0) || (cnt_ff == CNT_W'(NUMBER_BITS - 1))) begin
                     div_done_in = 1'b1;
                  end
               end else begin
                  rem_in = rem_new;
                  stp_in = stp_ff + 1'b1;
               end
            end
            if (!chk_done_ff) begin
               bad_in = bad_ff || chk_bad;
               if (chk_ff == REM_W'(MAX_RADIX - 1)) begin
                  chk_done_in = 1'b1;
               end else begin
                  chk_in = chk_ff + 1'b1;
               end
            end
            if (div_done_ff && chk_done_ff) begin
               if (bad_ff) begin
                  state_in = ST_BAD;
               end else begin
                  state_in = ST_EMIT_RD;
                  ptr_in   = ADDR_W'(cnt_ff - 1'b1);
               end
            end
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end

         ST_EMIT_LD: begin
            // The read register holds the digit at ptr; emit it, most significant first,
            // and fetch the next one in the same cycle.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sym[rd_data_ff];
               rsp_last_in  = (ptr_ff == '0);
               rsp_bad_in   = 1'b0;
               rsp_count_in = (ptr_ff == '0) ? rde_pkg::COUNT_W'(cnt_ff) : '0;
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in  = ptr_ff - 1'b1;
                  rd_addr = ptr_ff - 1'b1;
               end
            end
         end

         ST_BAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rde_pkg::CHAR_NUL;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               rsp_count_in = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_done_ff  <= 1'b0;
         div_done_ff  <= 1'b0;
         bad_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_done_ff  <= chk_done_in;
         div_done_ff  <= div_done_in;
         bad_ff       <= bad_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      stp_ff       <= stp_in;
      chk_ff       <= chk_in;
      ptr_ff       <= ptr_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_bad_base   = rsp_bad_ff;
   assign rsp_char_count = rsp_count_ff;

   // A bad-base result is the sole, final item and carries no character or count.
   `RDE_ASSERT_NOW(a_bad_item_shape, rsp_valid && rsp_bad_base, rsp_last && (rsp_char_count == '0) && (rsp_digit_char == rde_pkg::CHAR_NUL))
   // Only the last item of a number carries a character count.
   `RDE_ASSERT_NOW(a_count_on_last, rsp_valid && !rsp_last, rsp_char_count == '0)
   // During emission the read pointer stays inside the digits of this number.
   `RDE_ASSERT_NOW(a_ptr_in_range, state_ff == ST_EMIT_LD, (cnt_ff != '0) && (CNT_W'(ptr_ff) < cnt_ff))
   // Loading the least significant digit ends the number and frees the input side.
   `RDE_ASSERT_NEXT(a_last_ends_item, (state_ff == ST_EMIT_LD) && out_free && (ptr_ff == '0), rsp_valid && rsp_last && (state_ff == ST_IDLE))

endmodule

// ===== tb/tb_radix_digit_emitter.sv =====
module tb_radix_digit_emitter;
   timeunit 1ns;
   timeprecision 1ps;

   // The instance keeps its default sizes. The checker needs the same values.
   localparam int MAX_RADIX    = 16;
   localparam int NUMBER_BITS  = 32;
   // Index 3 decodes to no register. A write there must change nothing.
   localparam rde_pkg::csr_index_type CSR_UNMAPPED = 2'd3;
   localparam int RANDOM_ITEMS = 300;
   localparam int REPORT_LIMIT = 10;

   // Hexadecimal alphabet "0123456789ABCDEF" in the register byte packing.
   localparam logic [rde_pkg::CFG_W-1:0] HEX_LO = 64'h3736_3534_3332_3130;
   localparam logic [rde_pkg::CFG_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;

   // One character on the result channel, with its side-band fields.
   typedef struct packed {
      rde_pkg::char_type             digit_char;
      logic                          last;
      logic                          bad_base;
      logic [rde_pkg::COUNT_W-1:0]   char_count;
   } digit_item_type;

   // Ways in which a random alphabet is spoiled on purpose.
   typedef enum {FLAW_NONE, FLAW_PLUS, FLAW_MINUS, FLAW_NUL, FLAW_REPEAT} alphabet_flaw_type;

   // Patterns that the result side uses to push back.
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [rde_pkg::NUM_W-1:0]      req_number = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [rde_pkg::CHAR_W-1:0]     rsp_digit_char;
   logic                           rsp_last;
   logic                           rsp_bad_base;
   logic [rde_pkg::COUNT_W-1:0]    rsp_char_count;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   rde_pkg::csr_index_type         csr_index = rde_pkg::CSR_ALPHA_LO;
   logic [rde_pkg::CFG_W-1:0]      csr_data = '0;

   // The checker's own copy of the register file, at reset values.
   logic [rde_pkg::CFG_W-1:0]      alphabet_lo_copy = '0;
   logic [rde_pkg::CFG_W-1:0]      alphabet_hi_copy = '0;
   logic [rde_pkg::LEN_W-1:0]      radix_copy = '0;

   // Numbers waiting to be transferred, and characters predicted but not yet seen.
   logic [rde_pkg::NUM_W-1:0]      pending_numbers[$];
   digit_item_type                 digits_expected[$];

   int                    mismatches = 0;
   int                    burst_left = 0;
   int                    gap_left = 0;
   int                    mode_left = 0;
   int                    stall_tick = 0;
   stall_pattern_type     stall_mode = STALL_NONE;

   radix_digit_emitter #(
      .MAX_RADIX   (MAX_RADIX),
      .NUMBER_BITS (NUMBER_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_bad_base   (rsp_bad_base),
      .rsp_char_count (rsp_char_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Character k of the configured alphabet. The low register holds
   // characters 0 to 7 and the high register characters 8 to 15.
   function automatic rde_pkg::char_type symbol_at(int unsigned k);
      logic [rde_pkg::CFG_W-1:0] word;
      word = (k < 8) ? alphabet_lo_copy : alphabet_hi_copy;
      return word[8*(k%8) +: 8];
   endfunction

   // The alphabet is usable when its length is a legal radix and none of the
   // characters in use is a sign, a zero byte or a repeat of an earlier one.
   // Characters past the length play no part.
   function automatic bit alphabet_usable();
      int unsigned       n;
      rde_pkg::char_type c;
      n = 32'(radix_copy);
      if (n < rde_pkg::MIN_RADIX || n > MAX_RADIX) return 1'b0;
      for (int unsigned a = 0; a < n; a++) begin
         c = symbol_at(a);
         if (c == rde_pkg::CHAR_NUL || c == rde_pkg::CHAR_PLUS || c == rde_pkg::CHAR_MINUS)
            return 1'b0;
         for (int unsigned b = 0; b < a; b++) begin
            if (symbol_at(b) == c) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Works out the characters that one transferred number must produce and
   // queues them in emission order, most significant digit first.
   function automatic void predict_digits(logic [rde_pkg::NUM_W-1:0] number);
      logic [rde_pkg::NUM_W-1:0] rest;
      logic [3:0]                digit_values [32];
      int unsigned               count;
      digit_item_type            item;
      if (!alphabet_usable()) begin
         // A broken alphabet yields one flagged item and nothing else.
         item.digit_char = rde_pkg::CHAR_NUL;
         item.last       = 1'b1;
         item.bad_base   = 1'b1;
         item.char_count = '0;
         digits_expected.push_back(item);
         return;
      end
      // Repeated division leaves the least significant digit first, so the
      // digits are emitted from the top of the list down. Zero still gives
      // one digit.
      rest  = number;
      count = 0;
      do begin
         digit_values[count] = 4'(rest % radix_copy);
         rest = rest / radix_copy;
         count++;
      end while (rest != 0 && count < 32);
      for (int k = count - 1; k >= 0; k--) begin
         item.digit_char = symbol_at(digit_values[k]);
         item.last       = (k == 0);
         item.bad_base   = 1'b0;
         item.char_count = (k == 0) ? rde_pkg::COUNT_W'(count) : '0;
         digits_expected.push_back(item);
      end
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents the numbers of the pending queue in bursts with gaps
   // between them. A number is predicted at the edge that transfers it, so
   // the prediction always sees the configuration the block holds then.
   // While the block stalls, the valid number is held unchanged.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : number_driver
      logic took;
      if (reset) begin
         req_valid  <= 1'b0;
         req_number <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            predict_digits(req_number);
            void'(pending_numbers.pop_front());
         end
         if (!req_valid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_numbers.size() != 0) begin
               req_valid  <= 1'b1;
               req_number <= pending_numbers[0];
               // At the end of a burst, pick the next burst length and the
               // pause before it. A third of the bursts follow on at once.
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result-side backpressure. The pattern switches at random between no
   // stall at all, light and heavy random stalls, and a fixed rhythm, so
   // that stalls land on every phase of the character stream.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_backpressure
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
         mode_left  = 0;
         stall_tick = 0;
      end else begin
         stall_tick++;
         if (mode_left == 0) begin
            stall_mode = stall_pattern_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= 1'($urandom_range(0, 1));
            default:     rsp_stall <= ((stall_tick % 7) < 3);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every transferred character is compared with the oldest
   // prediction. A character with nothing predicted is an error as well.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : digit_monitor
      digit_item_type seen;
      digit_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.digit_char = rsp_digit_char;
         seen.last       = rsp_last;
         seen.bad_base   = rsp_bad_base;
         seen.char_count = rsp_char_count;
         if (digits_expected.size() == 0) begin
            note_mismatch($sformatf("unpredicted char %h last %b bad_base %b count %0d",
                                    seen.digit_char, seen.last, seen.bad_base,
                                    seen.char_count));
         end else begin
            want = digits_expected.pop_front();
            if (seen.digit_char !== want.digit_char || seen.last !== want.last ||
                seen.bad_base !== want.bad_base || seen.char_count !== want.char_count) begin
               note_mismatch($sformatf(
                  "expected char %h last %b bad_base %b count %0d, got %h %b %b %0d",
                  want.digit_char, want.last, want.bad_base, want.char_count,
                  seen.digit_char, seen.last, seen.bad_base, seen.char_count));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Register writes. They are only issued while the block is idle. The
   // local copy is updated at the edge of the transfer. The task returns
   // at a falling edge, so the caller can queue numbers without racing
   // the driver.
   // ------------------------------------------------------------------
   task automatic write_csr(rde_pkg::csr_index_type index, logic [rde_pkg::CFG_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         rde_pkg::CSR_ALPHA_LO: alphabet_lo_copy = data;
         rde_pkg::CSR_ALPHA_HI: alphabet_hi_copy = data;
         rde_pkg::CSR_BASE_LEN: radix_copy = data[rde_pkg::LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_alphabet(logic [rde_pkg::CFG_W-1:0] lo,
                                   logic [rde_pkg::CFG_W-1:0] hi,
                                   logic [rde_pkg::CFG_W-1:0] length_word);
      write_csr(rde_pkg::CSR_ALPHA_LO, lo);
      write_csr(rde_pkg::CSR_ALPHA_HI, hi);
      write_csr(rde_pkg::CSR_BASE_LEN, length_word);
   endtask

   // Idle means that nothing is queued or presented, and every predicted
   // character has arrived. Every number yields at least one character, so
   // the block has nothing left in flight at that point.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_numbers.size() != 0 || req_valid || digits_expected.size() != 0);
   endtask

   task automatic one_number(logic [rde_pkg::NUM_W-1:0] number);
      pending_numbers.push_back(number);
      wait_idle();
   endtask

   // Writes a random alphabet. Most are valid with distinct characters in
   // use and arbitrary bytes after them. Some have an illegal length. Some
   // are spoiled by a sign, a zero byte or a repeated character.
   task automatic random_alphabet();
      rde_pkg::char_type         symbols [16];
      bit                        taken [256];
      rde_pkg::char_type         c;
      int unsigned               len;
      int unsigned               pick;
      int unsigned               a;
      int unsigned               b;
      alphabet_flaw_type         flaw;
      logic [rde_pkg::CFG_W-1:0] lo;
      logic [rde_pkg::CFG_W-1:0] hi;
      logic [rde_pkg::CFG_W-1:0] length_word;
      taken = '{default: 1'b0};
      pick = $urandom_range(0, 9);
      if (pick == 0)      len = $urandom_range(0, 1);
      else if (pick == 1) len = $urandom_range(17, 31);
      else                len = $urandom_range(2, 16);
      for (int k = 0; k < 16; k++) begin
         if (k < len) begin
            do c = rde_pkg::char_type'($urandom_range(1, 255));
            while (c == rde_pkg::CHAR_PLUS || c == rde_pkg::CHAR_MINUS || taken[c]);
            taken[c]   = 1'b1;
            symbols[k] = c;
         end else begin
            symbols[k] = rde_pkg::char_type'($urandom_range(0, 255));
         end
      end
      flaw = FLAW_NONE;
      if (len >= 2 && len <= 16 && $urandom_range(0, 4) == 0)
         flaw = alphabet_flaw_type'($urandom_range(1, 4));
      b = $urandom_range(1, len - 1);
      a = $urandom_range(0, b - 1);
      case (flaw)
         FLAW_PLUS:   symbols[b] = rde_pkg::CHAR_PLUS;
         FLAW_MINUS:  symbols[a] = rde_pkg::CHAR_MINUS;
         FLAW_NUL:    symbols[b] = rde_pkg::CHAR_NUL;
         FLAW_REPEAT: symbols[b] = symbols[a];
         default: ;
      endcase
      for (int k = 0; k < 8; k++) begin
         lo[8*k +: 8] = symbols[k];
         hi[8*k +: 8] = symbols[k+8];
      end
      // Only the low five bits of the length register count. Half of the
      // writes carry garbage above them.
      length_word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      length_word[rde_pkg::LEN_W-1:0] = len[rde_pkg::LEN_W-1:0];
      if ($urandom_range(0, 5) == 0) write_csr(CSR_UNMAPPED, {$urandom, $urandom});
      program_alphabet(lo, hi, length_word);
   endtask

   // Full-width values are the most frequent kind and set every bit both ways. The rest are
   // short values, values near the top, and single bits.
   function automatic logic [rde_pkg::NUM_W-1:0] random_number();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $urandom >> $urandom_range(1, 31);
         7:          return $urandom_range(0, 40);
         8:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default:    return 32'd1 << $urandom_range(0, 31);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int random_sent;
      int burst;
      random_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // After reset the length is zero, so the alphabet is too short.
      one_number(32'd7);

      // Hexadecimal: zero, the single-digit limit, the first two-digit value,
      // the full range, the top bit alone and 0x12345678.
      program_alphabet(HEX_LO, HEX_HI, 64'd16);
      pending_numbers.push_back(32'd0);
      pending_numbers.push_back(32'd15);
      pending_numbers.push_back(32'd16);
      pending_numbers.push_back(32'hFFFF_FFFF);
      pending_numbers.push_back(32'h8000_0000);
      pending_numbers.push_back(32'h1234_5678);
      wait_idle();

      // Binary over the same registers gives the longest output, 32 characters.
      // The fourteen characters past the length are ignored.
      write_csr(rde_pkg::CSR_BASE_LEN, 64'd2);
      pending_numbers.push_back(32'hFFFF_FFFF);
      pending_numbers.push_back(32'd1);
      pending_numbers.push_back(32'hAAAA_AAAA);
      wait_idle();

      // Decimal. Signs and zero bytes sit just past the length and must not count.
      program_alphabet(HEX_LO, 64'h0000_0000_2D2B_3938, 64'd10);
      pending_numbers.push_back(32'hFFFF_FFFF);
      pending_numbers.push_back(32'd1_000_000_000);
      pending_numbers.push_back(32'd9);
      wait_idle();

      // Illegal lengths: one below the minimum, one above the maximum, and the
      // largest value the register holds. The register is not saturated.
      // The last write has high garbage that must be dropped, which leaves
      // a legal radix of three.
      write_csr(rde_pkg::CSR_BASE_LEN, 64'd1);
      one_number(32'd5);
      write_csr(rde_pkg::CSR_BASE_LEN, 64'd17);
      one_number(32'd5);
      write_csr(rde_pkg::CSR_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
      one_number(32'd5);
      write_csr(rde_pkg::CSR_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
      one_number(32'd100);

      // A plus sign and a minus sign inside the alphabet in use.
      program_alphabet(64'h3736_3534_2B32_3130, HEX_HI, 64'd16);
      one_number(32'd42);
      program_alphabet(HEX_LO, 64'h2D45_4443_4241_3938, 64'd16);
      one_number(32'd42);

      // A zero byte as character 8 breaks radix 9, but radix 8 does not use it.
      program_alphabet(HEX_LO, 64'h4645_4443_4241_3900, 64'd9);
      one_number(32'd42);
      write_csr(rde_pkg::CSR_BASE_LEN, 64'd8);
      one_number(32'hFFFF_FFFF);

      // Character 15 repeats character 0. This is only a fault while both are in use.
      program_alphabet(HEX_LO, 64'h3045_4443_4241_3938, 64'd16);
      one_number(32'd42);
      write_csr(rde_pkg::CSR_BASE_LEN, 64'd15);
      one_number(32'hDEAD_BEEF);

      // A write to the unmapped index leaves the radix-15 setup unchanged.
      write_csr(CSR_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
      one_number(32'h0000_FFFF);

      // Random phases. Each one has a fresh alphabet and a short run of numbers.
      while (random_sent < RANDOM_ITEMS) begin
         random_alphabet();
         burst = $urandom_range(4, 24);
         repeat (burst) pending_numbers.push_back(random_number());
         random_sent += burst;
         wait_idle();
      end

      // Give any stray character time to show up before the verdict.
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[radix_digit_emitter] OK");
      end else begin
         $display("[radix_digit_emitter] ERROR");
      end
      $finish;
   end

   // The slowest legal run is about 350 numbers of 32 characters each, with
   // long stalls. This limit leaves several times what such a run needs.
   initial begin : watchdog
      #15_000_000;
      $display("[radix_digit_emitter] ERROR");
      $finish;
   end

endmodule
